[rtl/priority_task_scheduler_defines.svh]
// ----------------------------------------------------------------------------
// priority_task_scheduler_defines
// Assertion macros shared by the scheduler checkers.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_TASK_SCHEDULER_DEFINES_SVH
`define PRIORITY_TASK_SCHEDULER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define PTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define PTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg
// Types, constants and helpers for the priority task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int TASK_SLOTS      = 16;
  localparam int PRIORITY_LEVELS = 16;
  localparam int TICK_BITS       = 32;

  localparam int SLOT_W   = $clog2(TASK_SLOTS);
  localparam int LVL_W    = $clog2(PRIORITY_LEVELS);
  localparam int TASK_W   = 4;
  localparam int PRIO_W   = 4;
  localparam int OP_W     = 3;
  localparam int SLEEP_W  = 32;
  localparam int STATUS_W = 2;

  localparam int IN_W  = 48;
  localparam int OUT_W = 8;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic REG_PRIORITY_MODE  = 1'b0;
  localparam logic REG_PREEMPT_ENABLE = 1'b1;

  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

  typedef enum logic [2:0] {
    ST_INVALID = 3'd0,
    ST_READY   = 3'd2,
    ST_DELAYED = 3'd3,
    ST_BLOCKED = 3'd4
  } slot_state_t;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE   = 3'd0,
    OP_TICK     = 3'd1,
    OP_SLEEP    = 3'd2,
    OP_SCHEDULE = 3'd3,
    OP_BLOCK    = 3'd4,
    OP_RELEASE  = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEVEL,
    S_SCAN,
    S_ONE,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    slot_state_t          state;
    logic [LVL_W-1:0]     prio;
    logic [TICK_BITS-1:0] ticks;
  } slot_t;

  // packed so that task_res sits in the low bits, status on top
  typedef struct packed {
    status_t           status;
    logic              switch_request;
    logic              found;
    logic [TASK_W-1:0] task_res;
  } result_t;

  typedef struct packed {
    logic priority_mode;
    logic preempt_enable;
  } cfg_t;

  // first slot of a wrapping scan after the last one served
  function automatic logic [SLOT_W-1:0] start_after(input logic [TASK_W-1:0] last);
    logic [TASK_W:0] nxt;
    nxt = {1'b0, last} + {{TASK_W{1'b0}}, 1'b1};
    if (int'(last) >= TASK_SLOTS - 1) begin
      return '0;
    end
    return nxt[SLOT_W-1:0];
  endfunction

endpackage

[rtl/pts_slot_table.sv]
// ----------------------------------------------------------------------------
// pts_slot_table
// Task slot storage: one read/write address per cycle, async read.
// ----------------------------------------------------------------------------
module pts_slot_table
  import pts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [SLOT_W-1:0] addr,
  output slot_t             rd_slot,
  input  logic              wr_en,
  input  slot_t             wr_slot
);

  slot_state_t          state_mem [TASK_SLOTS];
  logic [LVL_W-1:0]     prio_mem  [TASK_SLOTS];
  logic [TICK_BITS-1:0] ticks_mem [TASK_SLOTS];

  assign rd_slot.state = state_mem[addr];
  assign rd_slot.prio  = prio_mem[addr];
  assign rd_slot.ticks = ticks_mem[addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        state_mem[i] <= ST_INVALID;
      end
    end else if (wr_en) begin
      state_mem[addr] <= wr_slot.state;
    end
  end

  // priority and count are only read once a create or sleep has written them
  always_ff @(posedge clk) begin
    if (wr_en) begin
      prio_mem[addr]  <= wr_slot.prio;
      ticks_mem[addr] <= wr_slot.ticks;
    end
  end

endmodule

[rtl/pts_cfg.sv]
// ----------------------------------------------------------------------------
// pts_cfg
// APB configuration registers: scheduling mode and preemption enable.
// ----------------------------------------------------------------------------
module pts_cfg
  import pts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic wr_fire;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_fire = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.priority_mode  <= 1'b1;
      cfg.preempt_enable <= 1'b1;
    end else if (wr_fire) begin
      case (reg_sel)
        REG_PRIORITY_MODE:  cfg.priority_mode  <= pwdata[0];
        REG_PREEMPT_ENABLE: cfg.preempt_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_PRIORITY_MODE:  prdata[0] = cfg.priority_mode;
      REG_PREEMPT_ENABLE: prdata[0] = cfg.preempt_enable;
      default: ;
    endcase
  end

endmodule

[rtl/pts_core.sv]
// ----------------------------------------------------------------------------
// pts_core
// Sequencer walking the slot table one entry a cycle through a shared
// compare/decrement unit; holds scheduling pointers and the current task.
// ----------------------------------------------------------------------------
module pts_core
  import pts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    operation,
  input  logic [TASK_W-1:0]  task_index,
  input  logic [PRIO_W-1:0]  priority_req,
  input  logic [SLEEP_W-1:0] sleep_ticks,
  output logic               done_valid,
  input  logic               done_ready,
  output result_t            result,
  output logic [SLOT_W-1:0]  tbl_addr,
  input  slot_t              tbl_rd,
  output logic               tbl_wr_en,
  output slot_t              tbl_wr
);

  seq_state_t state, state_next;

  op_t                  op, op_next;
  logic [TASK_W-1:0]    idx, idx_next;
  logic [LVL_W-1:0]     prio_in, prio_in_next;
  logic [TICK_BITS-1:0] ticks_in, ticks_in_next;
  logic [SLOT_W-1:0]    pos, pos_next;
  logic [SLOT_W-1:0]    k, k_next;
  logic [LVL_W-1:0]     best_lv, best_lv_next;
  logic                 best_ok, best_ok_next;
  logic [TASK_W-1:0]    rr_last, rr_last_next;
  logic [TASK_W-1:0]    level_last [PRIORITY_LEVELS];
  logic [TASK_W-1:0]    level_last_next [PRIORITY_LEVELS];
  logic [TASK_W-1:0]    current_task, current_task_next;
  result_t              res, res_next;

  logic                 in_fire;
  logic                 last_elem;
  logic [SLOT_W-1:0]    pos_adv;
  logic                 ready_hit;
  logic                 lvl_better;
  logic                 scan_hit;
  logic                 sleep_sat;

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign done_valid = (state == S_DONE);
  assign result     = res;
  assign tbl_addr   = pos;

  assign last_elem  = (k == SLOT_W'(TASK_SLOTS - 1));
  assign pos_adv    = (pos == SLOT_W'(TASK_SLOTS - 1)) ? '0 : pos + 1'b1;
  assign ready_hit  = (tbl_rd.state == ST_READY);
  assign lvl_better = ready_hit && (!best_ok || (tbl_rd.prio < best_lv));
  assign scan_hit   = ((op == OP_CREATE) && (tbl_rd.state == ST_INVALID)) ||
                      ((op == OP_SCHEDULE) && ready_hit &&
                       (!cfg.priority_mode || (tbl_rd.prio == best_lv)));
  assign sleep_sat  = (TICK_BITS < SLEEP_W) && ((sleep_ticks >> TICK_BITS) != '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (operation)
            OP_CREATE, OP_TICK:           state_next = S_SCAN;
            OP_SCHEDULE:                  state_next = cfg.priority_mode ? S_LEVEL : S_SCAN;
            OP_SLEEP, OP_BLOCK, OP_RELEASE: state_next = S_ONE;
            default:                      state_next = S_DONE;
          endcase
        end
      end
      S_LEVEL: begin
        if (last_elem) begin
          state_next = (best_ok || lvl_better) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_hit || last_elem) begin
          state_next = S_DONE;
        end
      end
      S_ONE:  state_next = S_DONE;
      S_DONE: begin
        if (done_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and table writes
  always_comb begin
    op_next           = op;
    idx_next          = idx;
    prio_in_next      = prio_in;
    ticks_in_next     = ticks_in;
    pos_next          = pos;
    k_next            = k;
    best_lv_next      = best_lv;
    best_ok_next      = best_ok;
    rr_last_next      = rr_last;
    level_last_next   = level_last;
    current_task_next = current_task;
    res_next          = res;
    tbl_wr_en         = 1'b0;
    tbl_wr            = tbl_rd;

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          op_next       = op_t'(operation);
          idx_next      = task_index;
          prio_in_next  = (int'(priority_req) >= PRIORITY_LEVELS) ?
                          LVL_W'(PRIORITY_LEVELS - 1) : priority_req[LVL_W-1:0];
          ticks_in_next = sleep_sat ? TICK_MAX : sleep_ticks[TICK_BITS-1:0];
          k_next        = '0;
          best_ok_next  = 1'b0;
          res_next      = '0;
          case (operation)
            OP_SLEEP, OP_BLOCK: pos_next = current_task[SLOT_W-1:0];
            OP_RELEASE:         pos_next = task_index[SLOT_W-1:0];
            OP_SCHEDULE:        pos_next = cfg.priority_mode ? '0 : start_after(rr_last);
            default:            pos_next = '0;
          endcase
        end
      end

      // pass one of priority mode: best level holding a ready task
      S_LEVEL: begin
        if (lvl_better) begin
          best_lv_next = tbl_rd.prio;
          best_ok_next = 1'b1;
        end
        pos_next = pos_adv;
        k_next   = k + 1'b1;
        if (last_elem) begin
          pos_next = start_after(level_last[best_lv_next]);
          k_next   = '0;
          if (!best_ok_next) begin
            res_next.status = STAT_NONE;
          end
        end
      end

      S_SCAN: begin
        pos_next = pos_adv;
        k_next   = k + 1'b1;
        case (op)
          OP_CREATE: begin
            if (scan_hit) begin
              tbl_wr_en        = 1'b1;
              tbl_wr.state     = ST_READY;
              tbl_wr.prio      = prio_in;
              tbl_wr.ticks     = '0;
              res_next.task_res = TASK_W'(pos);
              res_next.found   = 1'b1;
            end else if (last_elem) begin
              res_next.status = STAT_FULL;
            end
          end
          OP_TICK: begin
            if (tbl_rd.state == ST_DELAYED) begin
              tbl_wr_en = 1'b1;
              if (tbl_rd.ticks <= TICK_BITS'(1)) begin
                tbl_wr.state = ST_READY;
                tbl_wr.ticks = '0;
              end else begin
                tbl_wr.ticks = tbl_rd.ticks - TICK_BITS'(1);
              end
            end
            if (last_elem) begin
              res_next.switch_request = cfg.preempt_enable;
            end
          end
          OP_SCHEDULE: begin
            if (scan_hit) begin
              res_next.task_res = TASK_W'(pos);
              res_next.found    = 1'b1;
              current_task_next = TASK_W'(pos);
              if (cfg.priority_mode) begin
                level_last_next[best_lv] = TASK_W'(pos);
              end else begin
                rr_last_next = TASK_W'(pos);
              end
            end else if (last_elem) begin
              res_next.status = STAT_NONE;
            end
          end
          default: ;
        endcase
      end

      S_ONE: begin
        case (op)
          OP_SLEEP: begin
            if (ready_hit) begin
              tbl_wr_en    = 1'b1;
              tbl_wr.state = ST_DELAYED;
              tbl_wr.ticks = ticks_in;
              res_next.switch_request = 1'b1;
            end
          end
          OP_BLOCK: begin
            if (ready_hit) begin
              tbl_wr_en    = 1'b1;
              tbl_wr.state = ST_BLOCKED;
              res_next.switch_request = 1'b1;
            end
          end
          OP_RELEASE: begin
            if ((int'(idx) < TASK_SLOTS) && (tbl_rd.state == ST_BLOCKED)) begin
              tbl_wr_en    = 1'b1;
              tbl_wr.state = ST_READY;
            end
          end
          default: ;
        endcase
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rr_last      <= '1;
      current_task <= '0;
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        level_last[i] <= '1;
      end
    end else begin
      state        <= state_next;
      rr_last      <= rr_last_next;
      current_task <= current_task_next;
      level_last   <= level_last_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    idx      <= idx_next;
    prio_in  <= prio_in_next;
    ticks_in <= ticks_in_next;
    pos      <= pos_next;
    k        <= k_next;
    best_lv  <= best_lv_next;
    best_ok  <= best_ok_next;
    res      <= res_next;
  end

endmodule

[rtl/priority_task_scheduler.sv]
// One request in flight: the slot table has a single port walked one slot a cycle.
// The next request is taken while the previous result waits in the output register.
// Reset (rst, synchronous) marks every slot invalid, sets the mode and preempt
// registers to 1 and points all last-served pointers at the final slot.
// ----------------------------------------------------------------------------
// priority_task_scheduler
// Task slot table with round-robin or priority dispatch, tick and sleep.
// ----------------------------------------------------------------------------
module priority_task_scheduler
  import pts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // s_tdata: operation[2:0], task_index[6:3], priority_req[10:7],
  //          sleep_ticks[42:11], zero fill[47:43]
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,
  // m_tdata: task_res[3:0], found[4], switch_request[5], status[7:6]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t              cfg;
  logic              done_valid;
  logic              done_ready;
  result_t           result;
  logic [SLOT_W-1:0] tbl_addr;
  slot_t             tbl_rd;
  slot_t             tbl_wr;
  logic              tbl_wr_en;

  pts_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pts_slot_table u_table (
    .clk     (clk),
    .rst     (rst),
    .addr    (tbl_addr),
    .rd_slot (tbl_rd),
    .wr_en   (tbl_wr_en),
    .wr_slot (tbl_wr)
  );

  pts_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .operation    (s_tdata[2:0]),
    .task_index   (s_tdata[6:3]),
    .priority_req (s_tdata[10:7]),
    .sleep_ticks  (s_tdata[42:11]),
    .done_valid   (done_valid),
    .done_ready   (done_ready),
    .result       (result),
    .tbl_addr     (tbl_addr),
    .tbl_rd       (tbl_rd),
    .tbl_wr_en    (tbl_wr_en),
    .tbl_wr       (tbl_wr)
  );

  assign done_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done_valid && done_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      m_tdata <= result;
    end
  end

endmodule

[rtl/pts_checker.sv]
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "priority_task_scheduler_defines.svh"

module pts_checker
  import pts_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  status_t    out_st;
  logic [5:0] out_body;
  logic       out_stall;
  logic       out_fail;
  logic       out_known;
  logic       in_fire;

  assign out_st    = status_t'(m_tdata[7:6]);
  assign out_body  = m_tdata[5:0];
  assign out_stall = m_tvalid && !m_tready;
  assign out_fail  = m_tvalid && (out_st != STAT_OK);
  assign out_known = (out_st == STAT_OK) || (out_st == STAT_FULL) || (out_st == STAT_NONE);
  assign in_fire   = s_tvalid && s_tready;

  // a stalled result holds
  `PTS_ASSERT_NXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "stalled result changed")

  // a taken request keeps the sequencer busy, so the input is not ready in the next cycle
  `PTS_ASSERT_NXT(a_busy_after_req, in_fire, !s_tready, "request taken back to back")

  // a failed request carries no slot and no switch
  `PTS_ASSERT_IMP(a_fail_clean, out_fail, out_body == '0, "error status with payload")

  // only defined status codes are produced
  `PTS_ASSERT_IMP(a_status_code, m_tvalid, out_known, "undefined status code")

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[tb/tb_priority_task_scheduler.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_priority_task_scheduler
// Self-checking bench: random request streams against a built-in scheduler
// predictor, with stalls on both stream sides and mode changes over APB.
// ----------------------------------------------------------------------------
module tb_priority_task_scheduler;
  import pts_pkg::*;

  localparam int LIMIT_CYCLES    = 800000;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 40;
  localparam int ITEMS_PER_PHASE = 230;
  localparam int N_PHASES        = 6;
  // per phase, bit n is phase n
  localparam logic [N_PHASES-1:0] PHASE_MODE    = 6'b011001;
  localparam logic [N_PHASES-1:0] PHASE_PREEMPT = 6'b110101;

  localparam logic [APB_ADDR_W-1:0] ADDR_PRIORITY_MODE  = {REG_PRIORITY_MODE, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_PREEMPT_ENABLE = {REG_PREEMPT_ENABLE, 2'b00};

  // operation codes the block does not define
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

  // slot table predictor plus the queue of results still owed by the block
  class sched_scoreboard;
    slot_state_t          slot_st  [TASK_SLOTS];
    logic [LVL_W-1:0]     slot_pri [TASK_SLOTS];
    logic [TICK_BITS-1:0] slot_cnt [TASK_SLOTS];
    logic [TASK_W-1:0]    rr_ptr;
    logic [TASK_W-1:0]    lvl_ptr  [PRIORITY_LEVELS];
    logic [TASK_W-1:0]    cur_task;
    logic [4:0]           live_tasks;
    bit                   prio_mode;
    bit                   preempt;
    result_t              expected_results[$];
    int                   mismatches;

    function new();
      for (int i = 0; i < TASK_SLOTS; i++) begin
        slot_st[i]  = ST_INVALID;
        slot_pri[i] = '0;
        slot_cnt[i] = '0;
      end
      for (int i = 0; i < PRIORITY_LEVELS; i++) lvl_ptr[i] = 4'hF;
      rr_ptr     = 4'hF;
      cur_task   = '0;
      live_tasks = '0;
      prio_mode  = 1'b1;
      preempt    = 1'b1;
      mismatches = 0;
    endfunction

    function void set_config(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
      if (addr == ADDR_PRIORITY_MODE) prio_mode = data[0];
      else if (addr == ADDR_PREEMPT_ENABLE) preempt = data[0];
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function bit current_ready();
      return slot_st[cur_task] == ST_READY;
    endfunction

    // a blocked slot at random, or the fallback when none is blocked
    function logic [TASK_W-1:0] blocked_slot(logic [TASK_W-1:0] fallback);
      int unsigned cand[$];
      for (int i = 0; i < TASK_SLOTS; i++)
        if (slot_st[i] == ST_BLOCKED) cand.push_back(i);
      if (cand.size() == 0) return fallback;
      return TASK_W'(cand[$urandom_range(0, cand.size() - 1)]);
    endfunction

    // wrapping search for a ready slot after the last one served
    function int unsigned next_ready(logic [TASK_W-1:0] last, bit by_level,
                                     logic [LVL_W-1:0] lvl);
      int unsigned s;
      s = (int'(last) >= TASK_SLOTS - 1) ? 0 : int'(last) + 1;
      for (int k = 0; k < TASK_SLOTS; k++) begin
        if (slot_st[s] == ST_READY && (!by_level || slot_pri[s] == lvl)) return s;
        s = (s + 1) % TASK_SLOTS;
      end
      return TASK_SLOTS;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [TASK_W-1:0] idx,
                               logic [PRIO_W-1:0] prio, logic [SLEEP_W-1:0] ticks);
      result_t     r;
      int unsigned pick;
      r = '0;
      pick = TASK_SLOTS;
      case (op)
        OP_CREATE: begin
          for (int i = 0; i < TASK_SLOTS; i++)
            if (pick == TASK_SLOTS && slot_st[i] == ST_INVALID) pick = i;
          if (pick == TASK_SLOTS) begin
            r.status = STAT_FULL;
          end else begin
            slot_st[pick]  = ST_READY;
            slot_pri[pick] = (int'(prio) >= PRIORITY_LEVELS) ?
                             LVL_W'(PRIORITY_LEVELS - 1) : prio[LVL_W-1:0];
            slot_cnt[pick] = '0;
            live_tasks     = live_tasks + 1'b1;
            r.task_res     = TASK_W'(pick);
            r.found        = 1'b1;
          end
        end
        OP_TICK: begin
          for (int i = 0; i < TASK_SLOTS; i++) begin
            if (slot_st[i] == ST_DELAYED) begin
              if (slot_cnt[i] <= 1) begin
                slot_cnt[i] = '0;
                slot_st[i]  = ST_READY;
              end else begin
                slot_cnt[i] = slot_cnt[i] - 1'b1;
              end
            end
          end
          r.switch_request = preempt;
        end
        OP_SLEEP: begin
          if (int'(cur_task) < TASK_SLOTS && slot_st[cur_task] == ST_READY) begin
            slot_st[cur_task]  = ST_DELAYED;
            slot_cnt[cur_task] = (ticks > TICK_MAX) ? TICK_MAX : ticks[TICK_BITS-1:0];
            r.switch_request   = 1'b1;
          end
        end
        OP_SCHEDULE: begin
          if (!prio_mode) begin
            pick = next_ready(rr_ptr, 1'b0, '0);
            if (pick < TASK_SLOTS) rr_ptr = TASK_W'(pick);
          end else begin
            for (int lv = 0; lv < PRIORITY_LEVELS; lv++) begin
              if (pick == TASK_SLOTS) begin
                pick = next_ready(lvl_ptr[lv], 1'b1, LVL_W'(lv));
                if (pick < TASK_SLOTS) lvl_ptr[lv] = TASK_W'(pick);
              end
            end
          end
          if (pick < TASK_SLOTS) begin
            cur_task   = TASK_W'(pick);
            r.task_res = TASK_W'(pick);
            r.found    = 1'b1;
          end else begin
            r.status = STAT_NONE;
          end
        end
        OP_BLOCK: begin
          if (int'(cur_task) < TASK_SLOTS && slot_st[cur_task] == ST_READY) begin
            slot_st[cur_task] = ST_BLOCKED;
            r.switch_request  = 1'b1;
          end
        end
        OP_RELEASE: begin
          if (int'(idx) < TASK_SLOTS && slot_st[idx] == ST_BLOCKED) slot_st[idx] = ST_READY;
        end
        default: ;
      endcase
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [OUT_W-1:0] raw);
      result_t got;
      result_t want;
      got = raw;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: task %0d found %0b switch %0b status %0d",
                   $time, got.task_res, got.found, got.switch_request, got.status);
        return;
      end
      want = expected_results.pop_front();
      if (got.task_res !== want.task_res || got.found !== want.found ||
          got.switch_request !== want.switch_request || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch task/found/switch/status: exp %0d/%0b/%0b/%0d got %0d/%0b/%0b/%0d",
                   $time, want.task_res, want.found, want.switch_request, want.status,
                   got.task_res, got.found, got.switch_request, got.status);
      end
    endfunction
  endclass

  logic                  clk     = 1'b0;
  logic                  rst     = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // s_tdata: operation[2:0], task_index[6:3], priority_req[10:7],
  //          sleep_ticks[42:11], zero fill[47:43]
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // m_tdata: task_res[3:0], found[4], switch_request[5], status[7:6]
  logic [OUT_W-1:0]      m_tdata;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  sched_scoreboard sb;
  int  cycles;
  int  hold_requests;
  int  hold_seen;
  int  hold_left;
  int  pat_mode;
  int  pat_left;
  int  pat_phase;
  int  burst_left;
  int  no_gap_left;
  bit  valid_high;

  priority_task_scheduler dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: long hold-offs on demand, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_mode = $urandom_range(0, 2);
        pat_left = $urandom_range(20, 200);
      end
      pat_left--;
      pat_phase++;
      case (pat_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= ($urandom_range(0, 99) < 65);
        default: m_tready <= ((pat_phase % 5) >= 2);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_config(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic sender_idle();
    if (valid_high) begin
      s_tvalid  <= 1'b0;
      valid_high = 1'b0;
    end
  endtask

  // offer one request, note it when taken, then maybe leave a gap
  task automatic send_request(logic [OP_W-1:0] op, logic [TASK_W-1:0] idx,
                              logic [PRIO_W-1:0] prio, logic [SLEEP_W-1:0] ticks);
    s_tdata   <= {5'b0, ticks, prio, idx, op};
    s_tvalid  <= 1'b1;
    valid_high = 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, idx, prio, ticks);
    if (no_gap_left > 0) begin
      no_gap_left--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      sender_idle();
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 10);
    end
  endtask

  task automatic random_request();
    int unsigned       r;
    logic [OP_W-1:0]   op;
    logic [TASK_W-1:0] idx;
    logic [PRIO_W-1:0] prio;
    logic [SLEEP_W-1:0] ticks;
    r     = $urandom_range(0, 99);
    idx   = TASK_W'($urandom_range(0, 15));
    prio  = PRIO_W'($urandom_range(0, 15));
    ticks = $urandom;
    if (r < 12)      op = OP_CREATE;
    else if (r < 32) op = OP_TICK;
    else if (r < 46) op = OP_SLEEP;
    else if (r < 74) op = OP_SCHEDULE;
    else if (r < 84) op = OP_BLOCK;
    else if (r < 96) op = OP_RELEASE;
    else if (r < 98) op = OP_UNUSED_6;
    else             op = OP_UNUSED_7;
    // crowd a few levels so priority mode has to rotate
    if (op == OP_CREATE && $urandom_range(0, 9) < 7) prio = PRIO_W'($urandom_range(0, 3));
    // a long sleep parks a slot for good, keep those rare
    if (op == OP_SLEEP && sb.current_ready() && $urandom_range(0, 149) != 0)
      ticks = $urandom_range(0, 6);
    if (op == OP_RELEASE && $urandom_range(0, 9) < 8) idx = sb.blocked_slot(idx);
    send_request(op, idx, prio, ticks);
  endtask

  task automatic wait_drained();
    sender_idle();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, then a small set of tasks walked through every operation
    send_request(OP_SCHEDULE, 4'd0, 4'd0, 32'd0);
    send_request(OP_BLOCK, 4'd0, 4'd0, 32'd0);
    send_request(OP_SLEEP, 4'd0, 4'd0, 32'hFFFF_FFFF);
    send_request(OP_RELEASE, 4'd0, 4'd0, 32'd0);
    send_request(OP_CREATE, 4'd0, 4'd15, 32'd0);
    send_request(OP_CREATE, 4'd0, 4'd0, 32'd0);
    send_request(OP_CREATE, 4'd15, 4'd0, 32'hFFFF_FFFF);
    send_request(OP_SCHEDULE, 4'd0, 4'd0, 32'd0);
    send_request(OP_SCHEDULE, 4'd0, 4'd0, 32'd0);
    send_request(OP_SCHEDULE, 4'd0, 4'd0, 32'd0);
    send_request(OP_SLEEP, 4'd0, 4'd0, 32'd0);       // zero sleep wakes on next tick
    send_request(OP_SCHEDULE, 4'd0, 4'd0, 32'd0);
    send_request(OP_TICK, 4'd0, 4'd0, 32'd0);
    send_request(OP_BLOCK, 4'd0, 4'd0, 32'd0);
    send_request(OP_SCHEDULE, 4'd0, 4'd0, 32'd0);
    send_request(OP_RELEASE, 4'd2, 4'd0, 32'd0);
    send_request(OP_RELEASE, 4'd15, 4'd15, 32'd0);
    send_request(OP_UNUSED_6, 4'd15, 4'd15, 32'hFFFF_FFFF);
    send_request(OP_UNUSED_7, 4'd15, 4'd15, 32'hFFFF_FFFF);
    send_request(OP_SCHEDULE, 4'd0, 4'd0, 32'd0);
    send_request(OP_SLEEP, 4'd0, 4'd0, 32'd3);
    send_request(OP_TICK, 4'd0, 4'd0, 32'd0);
    send_request(OP_TICK, 4'd0, 4'd0, 32'd0);
    send_request(OP_TICK, 4'd0, 4'd0, 32'd0);
    send_request(OP_SCHEDULE, 4'd0, 4'd0, 32'd0);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      apb_write(ADDR_PRIORITY_MODE, {31'b0, PHASE_MODE[ph]});
      apb_write(ADDR_PREEMPT_ENABLE, {31'b0, PHASE_PREEMPT[ph]});
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // result side stops while requests keep coming, so the input backs up
        if (ph % 2 == 1 && n == 60) begin
          hold_requests++;
          no_gap_left = 50;
        end
        random_request();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
